// ===== src/spibm_pkg.sv =====
// ----------------------------------------------------------------------------
// spibm_pkg
// Shared types and constants of the SPI register bank with bit modify.
// ----------------------------------------------------------------------------
package spibm_pkg;

  // Command opcodes carried by the first byte of a frame
  localparam logic [7:0] OP_WRITE  = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_MODIFY = 8'h05;
  localparam logic [7:0] OP_RESET  = 8'hC0;

  // Special register addresses and values
  localparam logic [6:0] ADDR_STATUS  = 7'h0E;
  localparam logic [6:0] ADDR_CONTROL = 7'h0F;
  localparam logic [7:0] MODE_CONFIG  = 8'h80;
  localparam logic [7:0] MODE_FIELD   = 8'hE0;

  // Position of the next byte within a frame
  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_ADDR = 2'd1,
    PH_MASK = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  // Command latched for the rest of the frame
  typedef enum logic [1:0] {
    AC_NONE   = 2'd0,
    AC_READ   = 2'd1,
    AC_WRITE  = 2'd2,
    AC_MODIFY = 2'd3
  } command_e;

  // Input transfer: shifted byte or frame end
  typedef struct packed {
    logic       action;
    logic [7:0] mosi_byte;
  } in_t;

  // Result transfer: one per shifted byte
  typedef struct packed {
    logic [7:0] miso_byte;
    logic [2:0] mode_bits;
  } out_t;

endpackage

// ===== src/spibm_ram.sv =====
// ----------------------------------------------------------------------------
// spibm_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module spibm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spi_register_bank_with_bit_modify.sv =====
// ----------------------------------------------------------------------------
// spi_register_bank_with_bit_modify
// SPI command front end: framed command, address, mask and data bytes drive
// read, write, bit modify and reset of a register bank held in a RAM.
// ----------------------------------------------------------------------------
//
//  channel  | ports                  | handshake
//  ---------+------------------------+-----------------------------------
//  input    | cmd_i (in_t)           | transfer when start && !busy
//  result   | result_o (out_t)       | done_o high one cycle, no stall
//
//  For a shifted byte the bank RAM is read at the accept edge
//  and the byte is applied and written back in the following cycle, during
//  which busy is high. The registered result strobe rises in the cycle after,
//  while the next byte may already be accepted. For a frame end busy stays
//  low and no result is produced. Reset and the RESET command clear the
//  per-entry valid bits at once; no clearing pass. The receiver cannot stall.
//
module spi_register_bank_with_bit_modify #(
  parameter int REG_COUNT = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  spibm_pkg::in_t     cmd_i,
  output logic               done_o,
  output spibm_pkg::out_t    result_o
);

  import spibm_pkg::*;

  // only 7 address bits reach the bank
  localparam int BankDepth = (REG_COUNT < 128) ? REG_COUNT : 128;
  localparam int IdxW      = $clog2(BankDepth);
  localparam logic [8:0] BankLimit = 9'(REG_COUNT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  command_e        cmd_q, cmd_d;
  logic [6:0]      addr_q, addr_d;
  logic [7:0]      mask_q, mask_d;
  logic [2:0]      mode_q, mode_d;
  logic [BankDepth-1:0] valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            done_q, done_d;
  out_t            result_q, result_d;

  logic            accept;
  logic            in_range;
  logic [IdxW-1:0] idx;
  logic [7:0]      rdata;
  logic [7:0]      rd_val;
  logic            ram_we;
  logic [7:0]      ram_wdata;

  assign accept   = start && !busy;
  assign busy     = (state_q == S_EXEC);
  assign in_range = ({2'b00, addr_q} < BankLimit);
  assign idx      = addr_q[IdxW-1:0];

  // bank storage; read issued at the accept edge
  spibm_ram #(
    .WIDTH (8),
    .DEPTH (BankDepth)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  // current register value: status lives in flops, unwritten entries reset
  always_comb begin
    if (!in_range) begin
      rd_val = 8'h00;
    end else if (addr_q == ADDR_STATUS) begin
      rd_val = {mode_q, 5'b0_0000};
    end else if (!valid_q[idx]) begin
      rd_val = (addr_q == ADDR_CONTROL) ? MODE_CONFIG : 8'h00;
    end else begin
      rd_val = rdata;
    end
  end

  // frame sequencer and read-modify-write
  always_comb begin
    logic       store;
    logic [7:0] store_val;
    state_d   = state_q;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    mask_d    = mask_q;
    mode_d    = mode_q;
    valid_d   = valid_q;
    done_d    = 1'b0;
    result_d  = result_q;
    store     = 1'b0;
    store_val = byte_q;
    ram_we    = 1'b0;
    ram_wdata = byte_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.action) begin
            phase_d = PH_CMD;
            cmd_d   = AC_NONE;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        result_d.miso_byte = 8'h00;
        unique case (phase_q)
          PH_CMD: begin
            phase_d = PH_ADDR;
            priority if (byte_q == OP_READ) begin
              cmd_d = AC_READ;
            end else if (byte_q == OP_WRITE) begin
              cmd_d = AC_WRITE;
            end else if (byte_q == OP_MODIFY) begin
              cmd_d = AC_MODIFY;
            end else begin
              cmd_d   = AC_NONE;
              phase_d = PH_DATA;
              if (byte_q == OP_RESET) begin
                valid_d = '0;
                mode_d  = MODE_CONFIG[7:5];
              end
            end
          end
          PH_ADDR: begin
            addr_d  = byte_q[6:0];
            phase_d = (cmd_q == AC_MODIFY) ? PH_MASK : PH_DATA;
          end
          PH_MASK: begin
            mask_d  = byte_q;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            unique case (cmd_q)
              AC_READ: begin
                result_d.miso_byte = rd_val;
                addr_d = addr_q + 7'd1;
              end
              AC_WRITE: begin
                store     = 1'b1;
                store_val = byte_q;
                addr_d    = addr_q + 7'd1;
              end
              AC_MODIFY: begin
                store     = 1'b1;
                store_val = (rd_val & ~mask_q) | (byte_q & mask_q);
                cmd_d     = AC_NONE;
              end
              AC_NONE: begin
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase

        // write back; status is read-only, control also sets the mode
        if (store && in_range && (addr_q != ADDR_STATUS)) begin
          ram_we       = 1'b1;
          ram_wdata    = store_val;
          valid_d[idx] = 1'b1;
          if (addr_q == ADDR_CONTROL) begin
            mode_d = store_val[7:5] & MODE_FIELD[7:5];
          end
        end

        result_d.mode_bits = mode_d;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_CMD;
      cmd_q   <= AC_NONE;
      addr_q  <= 7'd0;
      mask_q  <= 8'h00;
      mode_q  <= MODE_CONFIG[7:5];
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      mask_q  <= mask_d;
      mode_q  <= mode_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= cmd_i.mosi_byte;
    end
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // checks
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result strobe without an executed byte");

  a_byte_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cmd_i.action) |=> busy)
    else $error("shifted byte accepted without execution cycle");

  a_no_status_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_range && (addr_q != ADDR_STATUS)))
    else $error("bank write to status or beyond the bank");

  a_mode_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(state_q == S_EXEC) |-> $stable(mode_q))
    else $error("mode bits changed outside execution");

endmodule

// ===== verif/spi_register_bank_with_bit_modify_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_register_bank_with_bit_modify_tb
// Drives framed SPI bytes (command, address, mask, data, chip-select release)
// into the register bank and checks every returned byte and mode field against
// a bit-exact bank model kept inside the bench. A short directed part covers
// each command and corner; random frames, mostly well formed, make up the rest.
// ----------------------------------------------------------------------------
module spi_register_bank_with_bit_modify_tb;
  import spibm_pkg::*;

  localparam int  BANK_DEPTH     = 128;
  localparam int  ITEM_TARGET    = 1100;
  localparam int  SETTLE_CYCLES  = 4;
  localparam int  TAIL_CYCLES    = 8;
  localparam int  WATCHDOG_LIMIT = 1000;
  localparam int  IDLE_PERCENT   = 6;
  localparam int  REPORT_LIMIT   = 10;
  // Byte that decodes as no known command
  localparam logic [7:0] OP_BOGUS = 8'h81;

  // One queued stimulus entry: a byte or frame end, or a pause marker
  typedef struct packed {
    logic hold;
    logic calm;
    in_t  item;
  } pend_t;

  logic clk_i    = 1'b0;
  logic rst_ni   = 1'b0;
  logic start    = 1'b0;
  logic busy;
  in_t  cmd_i    = '0;
  logic done_o;
  out_t result_o;

  pend_t pend_q[$];
  out_t  reply_q[$];

  int    n_issued     = 0;
  int    n_checked    = 0;
  int    settle_cnt   = 0;
  int    quiet_cycles = 0;
  int    mismatch_cnt = 0;
  int    items_queued = 0;
  logic  calm_now     = 1'b0;

  // Bank model state
  phase_e     ph_m;
  command_e   cmd_m;
  logic [6:0] addr_m;
  logic [7:0] mask_m;
  logic [7:0] bank_m [BANK_DEPTH];

  spi_register_bank_with_bit_modify dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model ---
  function automatic void bank_wipe();
    for (int i = 0; i < BANK_DEPTH; i++) bank_m[i] = 8'h00;
    bank_m[ADDR_STATUS]  = MODE_CONFIG;
    bank_m[ADDR_CONTROL] = MODE_CONFIG;
  endfunction

  function automatic logic [7:0] bank_fetch(input logic [6:0] a);
    if (int'(a) < BANK_DEPTH) return bank_m[a];
    return 8'h00;
  endfunction

  // Status is read-only; control mirrors its mode field into status
  function automatic void bank_put(input logic [6:0] a, input logic [7:0] v);
    if (int'(a) >= BANK_DEPTH || a == ADDR_STATUS) return;
    bank_m[a] = v;
    if (a == ADDR_CONTROL)
      bank_m[ADDR_STATUS] = (bank_m[ADDR_STATUS] & ~MODE_FIELD) | (v & MODE_FIELD);
  endfunction

  // Applies one transfer to the model; returns 1 when a reply byte is due
  function automatic logic apply_spi_byte(input in_t item, output out_t reply);
    logic [7:0] b;
    logic [7:0] old;
    b     = item.mosi_byte;
    reply = '0;
    if (item.action) begin
      ph_m  = PH_CMD;
      cmd_m = AC_NONE;
      return 1'b0;
    end
    case (ph_m)
      PH_CMD: begin
        ph_m = PH_ADDR;
        case (b)
          OP_READ:   cmd_m = AC_READ;
          OP_WRITE:  cmd_m = AC_WRITE;
          OP_MODIFY: cmd_m = AC_MODIFY;
          default: begin
            // reset acts at once; unknown or reset skips the rest of the frame
            if (b == OP_RESET) bank_wipe();
            cmd_m = AC_NONE;
            ph_m  = PH_DATA;
          end
        endcase
      end
      PH_ADDR: begin
        addr_m = b[6:0];
        ph_m   = (cmd_m == AC_MODIFY) ? PH_MASK : PH_DATA;
      end
      PH_MASK: begin
        mask_m = b;
        ph_m   = PH_DATA;
      end
      default: begin
        case (cmd_m)
          AC_READ: begin
            reply.miso_byte = bank_fetch(addr_m);
            addr_m          = addr_m + 7'd1;
          end
          AC_WRITE: begin
            bank_put(addr_m, b);
            addr_m = addr_m + 7'd1;
          end
          AC_MODIFY: begin
            old = bank_fetch(addr_m);
            bank_put(addr_m, (old & ~mask_m) | (b & mask_m));
            cmd_m = AC_NONE;
          end
          default: ;
        endcase
      end
    endcase
    reply.mode_bits = bank_m[ADDR_STATUS][7:5];
    return 1'b1;
  endfunction

  // ------------------------------------------------------------ stimulus ---
  task automatic queue_item(input logic act, input logic [7:0] b);
    pend_t p;
    p                = '0;
    p.calm           = calm_now;
    p.item.action    = act;
    p.item.mosi_byte = b;
    pend_q.push_back(p);
    items_queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_item(1'b0, b);
  endtask

  // Frame end carries a random don't-care byte
  task automatic queue_end();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    queue_item(1'b1, junk);
  endtask

  // Sender waits here until every reply is back
  task automatic queue_hold();
    pend_t p;
    p      = '0;
    p.hold = 1'b1;
    pend_q.push_back(p);
  endtask

  task automatic queue_random_frame();
    int          r;
    int          tail;
    logic [7:0]  opc;
    logic [7:0]  adr;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 30)      opc = OP_READ;
    else if (r < 60) opc = OP_WRITE;
    else if (r < 85) opc = OP_MODIFY;
    else if (r < 88) opc = OP_RESET;
    else             opc = 8'($urandom_range(0, 255));
    // favor status/control and a small window so reads hit written data
    r = $urandom_range(0, 99);
    if (r < 25)      adr = {$urandom_range(0, 1) == 1, ($urandom_range(0, 1) == 1) ?
                           ADDR_CONTROL : ADDR_STATUS};
    else if (r < 60) adr = {$urandom_range(0, 1) == 1, 7'($urandom_range(0, 15))};
    else             adr = 8'($urandom_range(0, 255));
    case (opc)
      OP_MODIFY:        tail = 3 + $urandom_range(0, 1);
      OP_READ, OP_WRITE: tail = 1 + $urandom_range(1, 6);
      default:          tail = $urandom_range(0, 3);
    endcase
    // broken frame: cut short
    if ($urandom_range(0, 99) < 8) tail = $urandom_range(0, tail);
    queue_byte(opc);
    for (int i = 0; i < tail; i++) begin
      b = (i == 0) ? adr : 8'($urandom_range(0, 255));
      queue_byte(b);
    end
    // broken frame: chip select never released
    if ($urandom_range(0, 99) < 92) queue_end();
  endtask

  // --------------------------------------------------------------- driver ---
  always @(posedge clk_i) begin : drive_blk
    out_t reply;
    logic has_reply;
    logic nxt_start;
    in_t  nxt_cmd;
    nxt_start = 1'b0;
    nxt_cmd   = cmd_i;
    if (rst_ni) begin
      // transfer accepted at this edge
      if (start && !busy) begin
        has_reply = apply_spi_byte(cmd_i, reply);
        if (has_reply) begin
          reply_q.push_back(reply);
          n_issued++;
        end
        void'(pend_q.pop_front());
      end
      // pause marker: drain all replies, then let the pipeline settle
      if (pend_q.size() != 0 && pend_q[0].hold) begin
        if (n_issued == n_checked) settle_cnt++;
        else settle_cnt = 0;
        if (settle_cnt >= SETTLE_CYCLES) begin
          void'(pend_q.pop_front());
          settle_cnt = 0;
        end
      end
      if (pend_q.size() != 0 && !pend_q[0].hold) begin
        if (pend_q[0].calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
          nxt_start = 1'b1;
          nxt_cmd   = pend_q[0].item;
        end
      end
    end
    start <= nxt_start;
    cmd_i <= nxt_cmd;
  end

  // -------------------------------------------------------------- monitor ---
  task automatic log_mismatch(input string what, input logic [7:0] want,
                              input logic [7:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT)
      $display("%0t %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_blk
    out_t want;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        log_mismatch("unexpected reply", 8'h00, result_o.miso_byte);
      end else begin
        want = reply_q.pop_front();
        n_checked <= n_checked + 1;
        if (result_o.miso_byte !== want.miso_byte)
          log_mismatch("miso_byte", want.miso_byte, result_o.miso_byte);
        if (result_o.mode_bits !== want.mode_bits)
          log_mismatch("mode_bits", 8'(want.mode_bits), 8'(result_o.mode_bits));
      end
    end
  end

  // ------------------------------------------------------------- watchdog ---
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("spi_register_bank_with_bit_modify: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- sequence ---
  initial begin
    ph_m   = PH_CMD;
    cmd_m  = AC_NONE;
    addr_m = '0;
    mask_m = '0;
    bank_wipe();

    // frame end with no frame open
    queue_end();
    // read status then control; address bit 7 is dropped
    queue_byte(OP_READ);
    queue_byte({1'b1, ADDR_STATUS});
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_end();
    // write across the top of the bank: address wraps to zero
    queue_byte(OP_WRITE);
    queue_byte(8'h7F);
    queue_byte(8'hAA);
    queue_byte(8'h55);
    queue_end();
    // write to status is dropped, next byte lands in control
    queue_byte(OP_WRITE);
    queue_byte({1'b0, ADDR_STATUS});
    queue_byte(8'h12);
    queue_byte(8'h34);
    queue_end();
    // bit modify on control, trailing byte ignored
    queue_byte(OP_MODIFY);
    queue_byte({1'b0, ADDR_CONTROL});
    queue_byte(8'hF0);
    queue_byte(8'hA5);
    queue_byte(8'h77);
    queue_end();
    // reset command, rest of frame ignored
    queue_byte(OP_RESET);
    queue_byte(8'h33);
    queue_end();
    // unknown command swallows a read opcode
    queue_byte(OP_BOGUS);
    queue_byte(OP_READ);
    queue_end();
    queue_hold();

    // random frames; a stretch with no sender gaps, pauses now and then
    while (items_queued < ITEM_TARGET) begin
      calm_now = (items_queued >= 400 && items_queued < 650);
      if (items_queued % 350 < 6) queue_hold();
      queue_random_frame();
    end
    queue_end();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pend_q.size() != 0 || n_issued != n_checked);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (reply_q.size() != 0)
      log_mismatch("replies never produced", 8'(reply_q.size()), 8'h00);

    if (mismatch_cnt == 0) begin
      $display("spi_register_bank_with_bit_modify: match");
    end else begin
      $display("spi_register_bank_with_bit_modify: mismatch");
    end
    $finish;
  end

endmodule
